// ===== rtl/single_wire_humidity_sensor_reader_macros.svh =====
// Assertion macros for the single-wire humidity sensor reader.
`ifndef SINGLE_WIRE_HUMIDITY_SENSOR_READER_MACROS_SVH
`define SINGLE_WIRE_HUMIDITY_SENSOR_READER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SWHR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SWHR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/swhr_pkg.sv =====
// Shared types, constants and functions for the single-wire humidity sensor reader.
`timescale 1ns / 1ps

package swhr_pkg;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int TICK_W     = 16;
    localparam int LAST_W     = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_START_LOW_TICKS     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_TICKS       = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_THRESHOLD_TICKS = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECKSUM_TOLERANCE  = 8'd3;

    localparam logic [15:0] START_LOW_RESET     = 16'd18000;
    localparam logic [7:0]  RELEASE_RESET       = 8'd20;
    localparam logic [7:0]  THRESHOLD_RESET     = 8'd33;
    localparam logic [7:0]  TOLERANCE_RESET     = 8'd5;
    localparam logic [TICK_W-1:0] TICK_MAX      = 16'hFFFF;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_DRIVE    = 4'd1,
        PH_RELEASE  = 4'd2,
        PH_ACK_LOW  = 4'd3,
        PH_ACK_HIGH = 4'd4,
        PH_ACK_END  = 4'd5,
        PH_BIT_RISE = 4'd6,
        PH_BIT_TIME = 4'd7,
        PH_BIT_FALL = 4'd8
    } phase_t;

    typedef struct packed {
        logic [15:0] start_low_ticks;
        logic [7:0]  release_ticks;
        logic [7:0]  bit_threshold_ticks;
        logic [7:0]  checksum_tolerance;
    } cfg_t;

    typedef struct packed {
        phase_t              phase;
        logic [TICK_W-1:0]   tick_count;
        logic [LAST_W-1:0]   frame_shift;
        logic [LAST_W-1:0]   last_frame;
        logic                last_accepted;
    } core_state_t;

    // Wrapped sum of the four data bytes against the checksum byte.
    function automatic logic checksum_ok(input logic [LAST_W-1:0] frame,
                                         input logic [7:0] tol);
        logic [7:0] sum;
        logic [7:0] chk;
        logic [7:0] diff;
        sum  = frame[39:32] + frame[31:24] + frame[23:16] + frame[15:8];
        chk  = frame[7:0];
        diff = (chk > sum) ? (chk - sum) : (sum - chk);
        return (diff <= tol);
    endfunction

endpackage

// ===== rtl/swhr_cfg.sv =====
// Configuration register file for the single-wire humidity sensor reader.
`timescale 1ns / 1ps

module swhr_cfg
    import swhr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    // always writable; unknown indexes are dropped
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_low_ticks     <= START_LOW_RESET;
            cfg_reg.release_ticks       <= RELEASE_RESET;
            cfg_reg.bit_threshold_ticks <= THRESHOLD_RESET;
            cfg_reg.checksum_tolerance  <= TOLERANCE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_START_LOW_TICKS:     cfg_reg.start_low_ticks     <= cfg_data;
                CFG_RELEASE_TICKS:       cfg_reg.release_ticks       <= cfg_data[7:0];
                CFG_BIT_THRESHOLD_TICKS: cfg_reg.bit_threshold_ticks <= cfg_data[7:0];
                CFG_CHECKSUM_TOLERANCE:  cfg_reg.checksum_tolerance  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/swhr_step.sv =====
// One-tick next-state logic of the sensor protocol sequencer.
`timescale 1ns / 1ps

module swhr_step
    import swhr_pkg::*;
#(
    parameter int FRAME_BITS = 40,
    parameter int BIT_CNT_W  = $clog2(FRAME_BITS + 1)
)
(
    input  cfg_t                 cfg,
    input  core_state_t          cur,
    input  logic [BIT_CNT_W-1:0] bit_count,
    input  logic                 cmd,
    input  logic                 line_level,
    output core_state_t          nxt,
    output logic [BIT_CNT_W-1:0] bit_count_next,
    output logic                 done
);

    localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(FRAME_BITS);

    logic [TICK_W-1:0]    tick_inc;
    logic [TICK_W-1:0]    tick_sat;
    logic                 sample_hit;
    logic [BIT_CNT_W-1:0] bit_inc;
    logic                 last_bit;
    logic [LAST_W-1:0]    shifted;

    assign tick_inc   = cur.tick_count + TICK_W'(1);
    assign tick_sat   = (cur.tick_count != TICK_MAX) ? tick_inc : cur.tick_count;
    assign sample_hit = (tick_sat >= {8'd0, cfg.bit_threshold_ticks});
    assign bit_inc    = bit_count + BIT_CNT_W'(1);
    assign last_bit   = (bit_inc >= LAST_BIT);
    assign shifted    = {cur.frame_shift[LAST_W-2:0], line_level};

    // next state
    always_comb
    begin
        nxt            = cur;
        bit_count_next = bit_count;
        if (cmd)
        begin
            // start is ignored mid-reading
            if (cur.phase == PH_IDLE)
            begin
                nxt.phase       = PH_DRIVE;
                nxt.tick_count  = '0;
                nxt.frame_shift = '0;
                bit_count_next  = '0;
            end
        end
        else
        begin
            case (cur.phase)
                PH_IDLE: ;
                PH_DRIVE:
                begin
                    nxt.tick_count = tick_inc;
                    if (tick_inc >= cfg.start_low_ticks)
                    begin
                        nxt.phase      = PH_RELEASE;
                        nxt.tick_count = '0;
                    end
                end
                PH_RELEASE:
                begin
                    nxt.tick_count = tick_inc;
                    if (tick_inc >= {8'd0, cfg.release_ticks})
                    begin
                        nxt.phase      = PH_ACK_LOW;
                        nxt.tick_count = '0;
                    end
                end
                PH_ACK_LOW:  if (!line_level) nxt.phase = PH_ACK_HIGH;
                PH_ACK_HIGH: if (line_level)  nxt.phase = PH_ACK_END;
                PH_ACK_END:  if (!line_level) nxt.phase = PH_BIT_RISE;
                PH_BIT_RISE:
                begin
                    if (line_level)
                    begin
                        nxt.phase      = PH_BIT_TIME;
                        nxt.tick_count = '0;
                    end
                end
                PH_BIT_TIME:
                begin
                    nxt.tick_count = tick_sat;
                    if (sample_hit)
                    begin
                        nxt.frame_shift = shifted;
                        nxt.tick_count  = '0;
                        if (last_bit)
                        begin
                            nxt.last_frame    = shifted;
                            nxt.last_accepted = checksum_ok(shifted,
                                                            cfg.checksum_tolerance);
                            nxt.phase         = PH_IDLE;
                            bit_count_next    = '0;
                        end
                        else
                        begin
                            bit_count_next = bit_inc;
                            nxt.phase      = line_level ? PH_BIT_FALL : PH_BIT_RISE;
                        end
                    end
                end
                PH_BIT_FALL: if (!line_level) nxt.phase = PH_BIT_RISE;
                default: nxt.phase = PH_IDLE;
            endcase
        end
    end

    // outputs
    always_comb
    begin
        done = 1'b0;
        if (!cmd && (cur.phase == PH_BIT_TIME) && sample_hit && last_bit)
        begin
            done = 1'b1;
        end
    end

endmodule

// ===== rtl/single_wire_humidity_sensor_reader.sv =====
// Single-wire humidity sensor reader: input register, protocol step and result register.
`timescale 1ns / 1ps

// Reads a DHT11-style humidity/temperature sensor over one wire. Each input
// transaction is one microsecond tick: cmd = 1 starts a reading, cmd = 0
// carries the sampled wire level. A start pulls the wire low (line_drive_low)
// for max(start_low_ticks, 1) ticks, releases it for max(release_ticks, 1)
// ticks, waits for the sensor's low-high-low acknowledge, then times
// FRAME_BITS high pulses; a bit is the wire level bit_threshold_ticks ticks
// after its rising edge (a threshold of 0 acts as 1). Bits shift in MSB
// first; the last 40 form humidity, temperature and checksum bytes.
// reading_accepted is set when the wrapped sum of the four data bytes lies
// within checksum_tolerance of the checksum byte. There is no timeout: a
// silent sensor keeps busy_res high until reset. A start while busy is
// ignored. Every input transaction yields exactly one result transaction,
// showing the state after that tick. Rate: one transaction per clock
// cycle while no result is stalled; input register, combinational step
// logic, then result register. A stalled result holds the input register,
// which then stalls the input side. Configuration is written through
// cfg_valid/cfg_ready (always ready); the user must write it only while no
// transactions are pending; the block does not enforce it. A write between
// ticks, even in the middle of a reading, applies from the next tick on.

module single_wire_humidity_sensor_reader
    import swhr_pkg::*;
#(
    parameter int FRAME_BITS = 40
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // tick channel
    input  logic                  tick_valid,
    output logic                  tick_stall,
    input  logic                  cmd,
    input  logic                  line_level,
    // result channel
    output logic                  res_valid,
    input  logic                  res_stall,
    output logic                  line_drive_low,
    output logic                  busy_res,
    output logic                  reading_done,
    output logic                  reading_accepted,
    output logic [7:0]            humidity_whole,
    output logic [7:0]            humidity_frac,
    output logic [7:0]            temperature_whole,
    output logic [7:0]            temperature_frac,
    output logic [7:0]            checksum_byte
);

    `include "single_wire_humidity_sensor_reader_macros.svh"

    localparam int BIT_CNT_W = $clog2(FRAME_BITS + 1);

    cfg_t cfg;

    // input register
    logic in_valid_reg;
    logic in_valid_next;
    logic in_cmd_reg;
    logic in_line_reg;

    // protocol state; updated together with the result register
    core_state_t          state_reg;
    core_state_t          state_next;
    logic [BIT_CNT_W-1:0] bit_count_reg;
    logic [BIT_CNT_W-1:0] bit_count_next;

    // result register
    logic res_valid_reg;
    logic res_valid_next;
    logic res_done_reg;
    logic done_next;

    logic tick_take;
    logic advance;

    swhr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    swhr_step #(
        .FRAME_BITS (FRAME_BITS),
        .BIT_CNT_W  (BIT_CNT_W)
    ) u_step (
        .cfg            (cfg),
        .cur            (state_reg),
        .bit_count      (bit_count_reg),
        .cmd            (in_cmd_reg),
        .line_level     (in_line_reg),
        .nxt            (state_next),
        .bit_count_next (bit_count_next),
        .done           (done_next)
    );

    // The held tick moves on once the result slot is free or being emptied.
    assign advance    = in_valid_reg && (!res_valid_reg || !res_stall);
    assign tick_stall = in_valid_reg && !advance;
    assign tick_take  = tick_valid && !tick_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (tick_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (advance)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            res_done_reg  <= 1'b0;
            bit_count_reg <= '0;
            state_reg     <= '{phase: PH_IDLE, default: '0};
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
            if (advance)
            begin
                res_done_reg  <= done_next;
                bit_count_reg <= bit_count_next;
                state_reg     <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_take)
        begin
            in_cmd_reg  <= cmd;
            in_line_reg <= line_level;
        end
    end

    // Result fields come straight from the state, which only moves when a
    // new result is loaded.
    assign res_valid         = res_valid_reg;
    assign line_drive_low    = (state_reg.phase == PH_DRIVE);
    assign busy_res          = (state_reg.phase != PH_IDLE);
    assign reading_done      = res_done_reg;
    assign reading_accepted  = state_reg.last_accepted;
    assign humidity_whole    = state_reg.last_frame[39:32];
    assign humidity_frac     = state_reg.last_frame[31:24];
    assign temperature_whole = state_reg.last_frame[23:16];
    assign temperature_frac  = state_reg.last_frame[15:8];
    assign checksum_byte     = state_reg.last_frame[7:0];

    // checks
    `SWHR_ASSERT_NOW(a_done_goes_idle, res_valid_reg && res_done_reg, !busy_res && (bit_count_reg == '0), "reading done while sequencer still busy")
    `SWHR_ASSERT_NEXT(a_advance_fills_result, advance, res_valid_reg, "advanced tick left no result")
    `SWHR_ASSERT_NOW(a_stall_only_when_blocked, tick_stall, in_valid_reg && res_valid_reg && res_stall, "tick stalled without a blocked result")

endmodule

// ===== dv/testbench.sv =====
// Testbench for the single-wire humidity sensor reader: queue-fed driver, predictor, monitor.
`timescale 1ns / 1ps

module testbench;
    import swhr_pkg::*;

    localparam int FRAME_BITS    = 40;
    localparam int CYCLE_LIMIT   = 5_000_000;  // worst stalls on every transaction, several times
    localparam int TAIL_CYCLES   = 8;          // two-stage pipeline, with margin
    localparam int LONG_HOLD     = 300;
    localparam int MAX_REPORTS   = 10;
    localparam int ITEM_TARGET   = 1500;       // ticks offered over the whole run
    localparam int CLOSING_ITEMS = 200;        // kept back for the closing stretch
    // highest register index; nothing lives above the checksum tolerance
    localparam logic [CFG_IDX_W-1:0] CFG_NO_SUCH_REG = 8'hFF;

    typedef struct packed {
        logic cmd;
        logic line;
    } tick_item_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy;
        logic       done;
        logic       accepted;
        logic [7:0] hum_whole;
        logic [7:0] hum_frac;
        logic [7:0] temp_whole;
        logic [7:0] temp_frac;
        logic [7:0] chk;
    } sensor_reading_t;

    // ---------------------------------------------------------------------
    // Signals towards the block; everything driven is known from time zero
    // ---------------------------------------------------------------------
    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_valid  = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  tick_valid = 1'b0;
    logic                  tick_stall;
    logic                  cmd        = 1'b0;
    logic                  line_level = 1'b0;
    logic                  res_valid;
    logic                  res_stall  = 1'b0;
    logic                  line_drive_low;
    logic                  busy_res;
    logic                  reading_done;
    logic                  reading_accepted;
    logic [7:0]            humidity_whole;
    logic [7:0]            humidity_frac;
    logic [7:0]            temperature_whole;
    logic [7:0]            temperature_frac;
    logic [7:0]            checksum_byte;

    // ---------------------------------------------------------------------
    // Predictor copy of the configuration and of the reader state
    // ---------------------------------------------------------------------
    logic [15:0]       start_low   = START_LOW_RESET;
    logic [7:0]        release_len = RELEASE_RESET;
    logic [7:0]        threshold   = THRESHOLD_RESET;
    logic [7:0]        tolerance   = TOLERANCE_RESET;
    phase_t            sensor_phase = PH_IDLE;
    logic [TICK_W-1:0] pulse_ticks  = '0;
    int                bits_seen    = 0;
    logic [63:0]       shift_bits   = '0;
    logic [39:0]       held_frame   = '0;
    logic              held_ok      = 1'b0;

    tick_item_t      tick_queue[$];          // ticks waiting to be offered
    sensor_reading_t expected_readings[$];   // predicted results, oldest first

    int fail_count     = 0;
    int send_gap       = 0;
    int stall_gap      = 0;
    int send_idle_odds = 0;   // 0 = sender never idles
    int stall_odds     = 0;   // 0 = receiver never stalls
    int hold_left      = 0;
    logic hold_wanted  = 1'b0;
    logic hold_spent   = 1'b0;
    int queued_items   = 0;   // ticks queued so far
    int cycles_run     = 0;

    single_wire_humidity_sensor_reader #(
        .FRAME_BITS(FRAME_BITS)
    ) uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .tick_valid       (tick_valid),
        .tick_stall       (tick_stall),
        .cmd              (cmd),
        .line_level       (line_level),
        .res_valid        (res_valid),
        .res_stall        (res_stall),
        .line_drive_low   (line_drive_low),
        .busy_res         (busy_res),
        .reading_done     (reading_done),
        .reading_accepted (reading_accepted),
        .humidity_whole   (humidity_whole),
        .humidity_frac    (humidity_frac),
        .temperature_whole(temperature_whole),
        .temperature_frac (temperature_frac),
        .checksum_byte    (checksum_byte)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------------
    // Predictor: one tick in, the result transaction it causes out
    // ---------------------------------------------------------------------
    function automatic sensor_reading_t advance_reader(input logic c, input logic l);
        sensor_reading_t r;
        logic [7:0]      sum;
        logic [7:0]      diff;
        logic            done;
        done = 1'b0;
        if (c)
        begin
            // a start while busy is dropped outright, time included
            if (sensor_phase == PH_IDLE)
            begin
                sensor_phase = PH_DRIVE;
                pulse_ticks  = '0;
                bits_seen    = 0;
                shift_bits   = '0;
            end
        end
        else
        begin
            case (sensor_phase)
                PH_DRIVE:
                begin
                    pulse_ticks = pulse_ticks + 1'b1;
                    if (pulse_ticks >= start_low)
                    begin
                        sensor_phase = PH_RELEASE;
                        pulse_ticks  = '0;
                    end
                end
                PH_RELEASE:
                begin
                    pulse_ticks = pulse_ticks + 1'b1;
                    if (pulse_ticks >= release_len)
                    begin
                        sensor_phase = PH_ACK_LOW;
                        pulse_ticks  = '0;
                    end
                end
                PH_ACK_LOW:  if (!l) sensor_phase = PH_ACK_HIGH;
                PH_ACK_HIGH: if (l)  sensor_phase = PH_ACK_END;
                PH_ACK_END:  if (!l) sensor_phase = PH_BIT_RISE;
                PH_BIT_RISE:
                begin
                    if (l)
                    begin
                        sensor_phase = PH_BIT_TIME;
                        pulse_ticks  = '0;
                    end
                end
                PH_BIT_TIME:
                begin
                    if (pulse_ticks != TICK_MAX) pulse_ticks = pulse_ticks + 1'b1;
                    // count is at least one here, so a zero threshold behaves as one
                    if (pulse_ticks >= threshold)
                    begin
                        shift_bits  = {shift_bits[62:0], l};
                        bits_seen   = bits_seen + 1;
                        pulse_ticks = '0;
                        if (bits_seen >= FRAME_BITS)
                        begin
                            held_frame = shift_bits[39:0];
                            sum  = held_frame[39:32] + held_frame[31:24] +
                                   held_frame[23:16] + held_frame[15:8];
                            diff = (held_frame[7:0] > sum) ? held_frame[7:0] - sum
                                                           : sum - held_frame[7:0];
                            held_ok      = (diff <= tolerance);
                            done         = 1'b1;
                            sensor_phase = PH_IDLE;
                            bits_seen    = 0;
                        end
                        else
                        begin
                            sensor_phase = l ? PH_BIT_FALL : PH_BIT_RISE;
                        end
                    end
                end
                PH_BIT_FALL: if (!l) sensor_phase = PH_BIT_RISE;
                default:     sensor_phase = PH_IDLE;
            endcase
        end
        r.drive_low  = (sensor_phase == PH_DRIVE);
        r.busy       = (sensor_phase != PH_IDLE);
        r.done       = done;
        r.accepted   = held_ok;
        r.hum_whole  = held_frame[39:32];
        r.hum_frac   = held_frame[31:24];
        r.temp_whole = held_frame[23:16];
        r.temp_frac  = held_frame[15:8];
        r.chk        = held_frame[7:0];
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Driver: offers queued ticks, predicts each accepted transaction
    // ---------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        tick_item_t item;
        if (!rst_n)
        begin
            tick_valid <= 1'b0;
            cmd        <= 1'b0;
            line_level <= 1'b0;
            send_gap   <= 0;
        end
        else
        begin
            if (tick_valid && !tick_stall)
                expected_readings.push_back(advance_reader(cmd, line_level));
            // a stalled transaction is held as it stands
            if (!(tick_valid && tick_stall))
            begin
                if (send_gap != 0)
                begin
                    send_gap   <= send_gap - 1;
                    tick_valid <= 1'b0;
                end
                else if (tick_queue.size() != 0 && send_idle_odds != 0 &&
                         $urandom_range(1, send_idle_odds) == 1)
                begin
                    // idle burst of random length, counted down in send_gap
                    send_gap   <= $urandom_range(0, 14);
                    tick_valid <= 1'b0;
                end
                else if (tick_queue.size() != 0)
                begin
                    item = tick_queue.pop_front();
                    tick_valid <= 1'b1;
                    cmd        <= item.cmd;
                    line_level <= item.line;
                end
                else
                begin
                    tick_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here and ORed into the stall below
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            hold_spent <= 1'b0;
        end
        else if (hold_wanted && !hold_spent)
        begin
            hold_left  <= LONG_HOLD;
            hold_spent <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: checks each accepted result against the oldest prediction
    // ---------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        sensor_reading_t got;
        sensor_reading_t want;
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            stall_gap <= 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                got = {line_drive_low, busy_res, reading_done, reading_accepted,
                       humidity_whole, humidity_frac, temperature_whole,
                       temperature_frac, checksum_byte};
                if (expected_readings.size() == 0)
                begin
                    fail_count = fail_count + 1;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: result with nothing expected: %h", $realtime, got);
                end
                else
                begin
                    want = expected_readings.pop_front();
                    if (got.drive_low !== want.drive_low || got.busy !== want.busy ||
                        got.done !== want.done || got.accepted !== want.accepted ||
                        got.hum_whole !== want.hum_whole || got.hum_frac !== want.hum_frac ||
                        got.temp_whole !== want.temp_whole ||
                        got.temp_frac !== want.temp_frac || got.chk !== want.chk)
                    begin
                        fail_count = fail_count + 1;
                        if (fail_count <= MAX_REPORTS)
                            $display({"%0t: mismatch drive/busy/done/acc exp %b%b%b%b got %b%b%b%b",
                                      " bytes exp %h %h %h %h %h got %h %h %h %h %h"},
                                     $realtime, want.drive_low, want.busy, want.done,
                                     want.accepted, got.drive_low, got.busy, got.done,
                                     got.accepted, want.hum_whole, want.hum_frac,
                                     want.temp_whole, want.temp_frac, want.chk,
                                     got.hum_whole, got.hum_frac, got.temp_whole,
                                     got.temp_frac, got.chk);
                    end
                end
            end
            if (hold_left != 0)
            begin
                res_stall <= 1'b1;
            end
            else if (stall_gap != 0)
            begin
                stall_gap <= stall_gap - 1;
                res_stall <= 1'b1;
            end
            else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
            begin
                stall_gap <= $urandom_range(0, 14);
                res_stall <= 1'b1;
            end
            else
            begin
                res_stall <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------
    task automatic queue_tick(input logic c, input logic l);
        tick_item_t t;
        t.cmd  = c;
        t.line = l;
        tick_queue.push_back(t);
        queued_items = queued_items + 1;
    endtask

    // A line tick inside a reading, now and then preceded by a stray start
    task automatic queue_busy_tick(input bit strays, input logic l);
        if (strays && $urandom_range(0, 29) == 0) queue_tick(1'b1, 1'($urandom_range(0, 1)));
        queue_tick(1'b0, l);
    endtask

    // Random data bytes; checksum exact, near, just outside tolerance, or anything
    function automatic logic [39:0] random_frame();
        logic [7:0] b4;
        logic [7:0] b3;
        logic [7:0] b2;
        logic [7:0] b1;
        logic [7:0] sum;
        logic [7:0] chk;
        b4  = 8'($urandom);
        b3  = 8'($urandom);
        b2  = 8'($urandom);
        b1  = 8'($urandom);
        sum = b4 + b3 + b2 + b1;
        case ($urandom_range(0, 3))
            0: chk = sum;
            1: chk = $urandom_range(0, 1) ? sum + 8'($urandom_range(0, tolerance))
                                          : sum - 8'($urandom_range(0, tolerance));
            2: chk = sum + tolerance + 8'd1;
            default: chk = 8'($urandom);
        endcase
        return {b4, b3, b2, b1, chk};
    endfunction

    // One whole exchange at the current settings: start, drive, release,
    // acknowledge, then forty timed high pulses. Noisy pulses toggle before
    // the sample point; a cut drops the tail of the exchange.
    task automatic queue_reading(input logic [39:0] frame, input bit noisy, input bit strays,
                                 input bit tight, input bit cut);
        int   t_eff;
        int   k;
        int   hi_len;
        int   i;
        int   first;
        logic b;
        t_eff = (threshold == 0) ? 1 : threshold;
        first = tick_queue.size();
        queue_tick(1'b1, 1'($urandom_range(0, 1)));
        if (strays) queue_tick(1'b1, 1'($urandom_range(0, 1)));   // start while busy
        repeat ((start_low == 0) ? 1 : start_low)
            queue_busy_tick(strays, 1'($urandom_range(0, 1)));
        repeat ((release_len == 0) ? 1 : release_len)
            queue_busy_tick(strays, 1'($urandom_range(0, 1)));
        // sensor acknowledge: low, high, low, with spare highs before it
        repeat (tight ? 0 : $urandom_range(0, 3)) queue_busy_tick(strays, 1'b1);
        repeat (tight ? 1 : $urandom_range(1, 4)) queue_busy_tick(strays, 1'b0);
        repeat (tight ? 1 : $urandom_range(1, 4)) queue_busy_tick(strays, 1'b1);
        repeat (tight ? 1 : $urandom_range(1, 4)) queue_busy_tick(strays, 1'b0);
        for (i = 39; i >= 0; i--)
        begin
            b = frame[i];
            queue_busy_tick(strays, 1'b1);   // rising edge
            hi_len = b ? t_eff : $urandom_range(1, t_eff);
            for (k = 1; k < t_eff; k++)
                queue_busy_tick(strays, noisy ? 1'($urandom_range(0, 1)) : (k < hi_len));
            if (i == 0)
            begin
                // last bit: the frame completes on the sample itself
                queue_tick(1'b0, b);
            end
            else
            begin
                queue_busy_tick(strays, b);
                if (b)
                begin
                    repeat (tight ? 0 : $urandom_range(0, 3)) queue_busy_tick(strays, 1'b1);
                    queue_busy_tick(strays, 1'b0);
                end
                repeat (tight ? 0 : $urandom_range(0, 3)) queue_busy_tick(strays, 1'b0);
            end
        end
        if (cut)
            repeat ($urandom_range(1, tick_queue.size() - first)) void'(tick_queue.pop_back());
    endtask

    // Wait until every tick is taken and every result has arrived
    task automatic drain();
        do @(negedge clk);
        while (tick_queue.size() != 0 || tick_valid || expected_readings.size() != 0);
    endtask

    // Drain, then walk any unfinished reading to its end so the block is idle
    task automatic settle();
        int t_eff;
        drain();
        while (sensor_phase != PH_IDLE)
        begin
            t_eff = (threshold == 0) ? 1 : threshold;
            case (sensor_phase)
                PH_DRIVE, PH_RELEASE:
                    repeat (int'(start_low) + int'(release_len) + 2) queue_tick(1'b0, 1'b0);
                PH_ACK_HIGH: queue_tick(1'b0, 1'b1);
                PH_BIT_RISE:
                begin
                    queue_tick(1'b0, 1'b1);
                    repeat (t_eff) queue_tick(1'b0, 1'b0);
                end
                PH_BIT_TIME: repeat (t_eff) queue_tick(1'b0, 1'b0);
                default: queue_tick(1'b0, 1'b0);   // a low moves every other phase on
            endcase
            drain();
        end
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_START_LOW_TICKS:     start_low   = data;
            CFG_RELEASE_TICKS:       release_len = data[7:0];
            CFG_BIT_THRESHOLD_TICKS: threshold   = data[7:0];
            CFG_CHECKSUM_TOLERANCE:  tolerance   = data[7:0];
            default: ;
        endcase
    endtask

    // 8-bit registers get junk in the upper byte, which must be dropped
    task automatic set_config(input logic [15:0] sl, input logic [7:0] rl,
                              input logic [7:0] thr, input logic [7:0] tol);
        write_register(CFG_START_LOW_TICKS, sl);
        write_register(CFG_RELEASE_TICKS, {8'($urandom), rl});
        write_register(CFG_BIT_THRESHOLD_TICKS, {8'($urandom), thr});
        write_register(CFG_CHECKSUM_TOLERANCE, {8'($urandom), tol});
    endtask

    task automatic set_idling(input int send_odds, input int recv_odds);
        @(posedge clk);
        send_idle_odds <= send_odds;
        stall_odds     <= recv_odds;
    endtask

    task automatic run_random_phase(input bit calm);
        int n;
        if (calm)
            set_idling(0, 0);
        else
            set_idling(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 12),
                       ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 12));
        // short timing so the run stays near its tick budget
        set_config(16'(($urandom_range(0, 4) != 0) ? $urandom_range(0, 30)
                                                   : $urandom_range(31, 100)),
                   8'(($urandom_range(0, 5) != 0) ? $urandom_range(0, 20)
                                                  : $urandom_range(21, 60)),
                   8'(($urandom_range(0, 5) != 0) ? $urandom_range(0, 3)
                                                  : $urandom_range(4, 12)),
                   8'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 10)
                                                  : $urandom_range(0, 255)));
        if ($urandom_range(0, 5) == 0)
            write_register(CFG_IDX_W'($urandom_range(int'(CFG_CHECKSUM_TOLERANCE) + 1,
                                                     int'(CFG_NO_SUCH_REG))),
                           CFG_DATA_W'($urandom));
        n = $urandom_range(1, 2);
        repeat (n)
        begin
            repeat ($urandom_range(0, 4)) queue_tick(1'b0, 1'($urandom_range(0, 1)));
            queue_reading(random_frame(), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'b0, $urandom_range(0, 7) == 0);
        end
        settle();
    endtask

    // ---------------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------------
    initial
    begin
        int   phase_no;
        int   i;
        logic b;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // power-on settings: idle ticks, a start and part of the long drive;
        // the drive is then cut short and the first bits run at the reset
        // release, threshold and tolerance
        set_idling(6, 6);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b0, 1'b1);
        queue_tick(1'b1, 1'b0);
        repeat (40) queue_tick(1'b0, 1'($urandom_range(0, 1)));
        drain();
        write_register(CFG_START_LOW_TICKS, 16'd4);
        repeat (int'(release_len) + 1) queue_tick(1'b0, 1'b1);
        queue_tick(1'b0, 1'b0);   // acknowledge low
        queue_tick(1'b0, 1'b1);   // acknowledge high
        queue_tick(1'b0, 1'b0);   // into the first bit
        for (i = 0; i < 3; i++)
        begin
            b = (i != 1);
            queue_tick(1'b0, 1'b1);                      // rising edge
            repeat (int'(threshold)) queue_tick(1'b0, b);  // last one is the sample
            if (b) queue_tick(1'b0, 1'b0);
        end
        drain();
        set_config(16'd4, 8'd20, 8'd1, 8'd5);
        settle();

        // shortest drive and release, zero threshold, zero tolerance:
        // wrapped exact sum accepted, off by one rejected, start while busy
        set_config(16'd0, 8'd0, 8'd0, 8'd0);
        queue_reading({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFC}, 1'b0, 1'b0, 1'b1, 1'b0);
        queue_reading({8'h00, 8'h00, 8'h00, 8'h00, 8'h01}, 1'b0, 1'b1, 1'b1, 1'b0);
        settle();

        // activity before the sample point, widest tolerance
        set_config(16'd1, 8'd1, 8'd3, 8'd255);
        queue_reading(random_frame(), 1'b1, 1'b1, 1'b0, 1'b0);
        settle();

        // every register at its top value: part of the drive, then the
        // whole release and the first bit at the longest threshold
        set_idling(0, 0);
        set_config(16'd65535, 8'd255, 8'd255, 8'd255);
        queue_tick(1'b1, 1'b1);
        repeat (20) queue_tick(1'b0, 1'b0);
        drain();
        write_register(CFG_START_LOW_TICKS, 16'd1);
        repeat (int'(release_len) + 1) queue_tick(1'b0, 1'b1);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b0, 1'b1);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b0, 1'b1);   // rising edge of the first bit
        repeat (int'(threshold)) queue_tick(1'b0, 1'b1);
        queue_tick(1'b0, 1'b0);
        drain();
        set_config(16'd1, 8'd1, 8'd1, 8'd255);
        settle();

        phase_no = 0;
        do
        begin
            phase_no = phase_no + 1;
            if (phase_no == 1)
            begin
                // receiver sits on its stall while ticks keep coming
                @(posedge clk);
                hold_wanted <= 1'b1;
            end
            run_random_phase(1'b0);
        end
        while (queued_items < ITEM_TARGET - CLOSING_ITEMS);

        // closing stretch with neither side idling
        run_random_phase(1'b1);

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_readings.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        while (cycles_run < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles_run = cycles_run + 1;
        end
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/swhr_pkg.sv
rtl/swhr_cfg.sv
rtl/swhr_step.sv
rtl/single_wire_humidity_sensor_reader.sv
dv/testbench.sv
